// ===== src/cdd_pkg.sv =====
// Shared types, constants and calendar tables for the date difference block.
`timescale 1ns / 1ps
`default_nettype none

package cdd_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int COUNT_W = 22;
	// Absolute day number from year 0; the largest year gives just under 6.0e6.
	localparam int NUM_W   = 23;
	// Leap day correction for all years before a given year.
	localparam int CORR_W  = 13;
	// Quotient of a year by one hundred.
	localparam int QUO_W   = 8;
	localparam int DOY_W   = 9;

	// floor(x / 100) == (x * 5243) >> 19 for every x below 43699.
	localparam int RECIP_W     = 13;
	localparam int PROD_W      = YEAR_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP100 = 13'd5243;
	localparam int RECIP_SHIFT = 19;

	localparam logic [8:0] DAYS_PER_YEAR = 9'd365;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QUO,
		ST_YEAR,
		ST_DAY,
		ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_QUO,
		OP_YEAR,
		OP_DAY,
		OP_FIN
	} op_t;

	typedef struct packed {
		logic load;
		op_t  op;
		logic sel;
		logic out_load;
	} cmd_t;

	// Length of a month; February depends on the leap flag. Zero for a bad month.
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	// Days in a common year before the first of the month.
	function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
		logic [DOY_W-1:0] days;
		case (m)
			4'd1:    days = 9'd0;
			4'd2:    days = 9'd31;
			4'd3:    days = 9'd59;
			4'd4:    days = 9'd90;
			4'd5:    days = 9'd120;
			4'd6:    days = 9'd151;
			4'd7:    days = 9'd181;
			4'd8:    days = 9'd212;
			4'd9:    days = 9'd243;
			4'd10:   days = 9'd273;
			4'd11:   days = 9'd304;
			4'd12:   days = 9'd334;
			default: days = 9'd0;
		endcase
		return days;
	endfunction

endpackage

`default_nettype wire

// ===== src/cdd_ctrl.sv =====
// Controller state machine that sequences the two dates through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module cdd_ctrl
	import cdd_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	output logic in_stall,
	output logic out_valid,
	input  wire  out_stall,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   sel_q, sel_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		sel_d        = sel_q;
		cmd.load     = 1'b0;
		cmd.op       = OP_NONE;
		cmd.sel      = sel_q;
		cmd.out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					sel_d    = 1'b0;
					state_d  = ST_QUO;
				end
			end
			ST_QUO: begin
				cmd.op  = OP_QUO;
				state_d = ST_YEAR;
			end
			ST_YEAR: begin
				cmd.op  = OP_YEAR;
				state_d = ST_DAY;
			end
			ST_DAY: begin
				cmd.op = OP_DAY;
				if (sel_q) begin
					state_d = ST_FIN;
				end else begin
					sel_d   = 1'b1;
					state_d = ST_QUO;
				end
			end
			ST_FIN: begin
				// The result register is free, or its beat leaves this cycle.
				if (!out_valid_q || !out_stall) begin
					cmd.op       = OP_FIN;
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ST_QUO && !sel_q)
		else $error("accepted beat did not start the first date");

	a_second_date: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DAY && !sel_q |=> state_q == ST_QUO && sel_q)
		else $error("second date not started after the first");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FIN))
		else $error("result appeared without a finish step");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_valid_q || !out_stall)
		else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

// ===== src/cdd_datapath.sv =====
// Datapath: captured dates, year quotient, leap correction, day numbers, result.
`timescale 1ns / 1ps
`default_nettype none

module cdd_datapath
	import cdd_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	input  cmd_t                cmd,
	input  wire                 cfg_write_en,
	input  wire                 cfg_write_data,
	input  wire  [YEAR_W-1:0]   first_year,
	input  wire  [MONTH_W-1:0]  first_month,
	input  wire  [DAY_W-1:0]    first_day,
	input  wire  [YEAR_W-1:0]   second_year,
	input  wire  [MONTH_W-1:0]  second_month,
	input  wire  [DAY_W-1:0]    second_day,
	output logic [COUNT_W-1:0]  day_count,
	output logic                date_invalid
);

	logic [YEAR_W-1:0]  fy_q, sy_q;
	logic [MONTH_W-1:0] fm_q, sm_q;
	logic [DAY_W-1:0]   fd_q, sd_q;
	logic [QUO_W-1:0]   quo_q;
	logic               leap_q;
	logic [CORR_W-1:0]  corr_q;
	logic [NUM_W-1:0]   n0_q, n1_q;
	logic               bad_q;
	logic [COUNT_W-1:0] day_count_q;
	logic               date_invalid_q;
	logic               include_end_day_q;

	logic [YEAR_W-1:0]  y_sel;
	logic [MONTH_W-1:0] m_sel;
	logic [DAY_W-1:0]   d_sel;
	logic [PROD_W-1:0]  prod;
	logic [YEAR_W:0]    quo100;
	logic               rem0, leap;
	logic [CORR_W-1:0]  c4, c100, c400, corr;
	logic [DAY_W-1:0]   len;
	logic               bad;
	logic [DOY_W-1:0]   doy;
	logic [NUM_W-1:0]   num;
	logic               first_earlier;
	logic [NUM_W-1:0]   lo, hi, diff;
	logic [NUM_W:0]     sum;
	logic [COUNT_W-1:0] count;

	assign y_sel = cmd.sel ? sy_q : fy_q;
	assign m_sel = cmd.sel ? sm_q : fm_q;
	assign d_sel = cmd.sel ? sd_q : fd_q;

	// Year divided by one hundred through a reciprocal multiply.
	assign prod = PROD_W'(y_sel) * PROD_W'(RECIP100);

	// Leap rule and leap days before the year, from the registered quotient.
	always_comb begin
		quo100 = (($bits(quo100))'(quo_q) << 6) + (($bits(quo100))'(quo_q) << 5)
			+ (($bits(quo100))'(quo_q) << 2);
		rem0   = (quo100 == ($bits(quo100))'(y_sel));
		leap   = (y_sel[1:0] == 2'b00) && (!rem0 || quo_q[1:0] == 2'b00);
		c4     = CORR_W'((($bits(quo100))'(y_sel) + ($bits(quo100))'(3)) >> 2);
		c100   = CORR_W'(quo_q) + CORR_W'(!rem0);
		c400   = CORR_W'(quo_q[QUO_W-1:2]) + CORR_W'(!(rem0 && quo_q[1:0] == 2'b00));
		corr   = c4 - c100 + c400;
	end

	// Day of year and absolute day number of the selected date.
	always_comb begin
		len = month_len(m_sel, leap_q);
		bad = !(m_sel inside {[MONTH_JAN:MONTH_DEC]}) || (d_sel == '0) || (d_sel > len);
		doy = bad ? '0 : cum_days(m_sel) + DOY_W'(leap_q && m_sel > MONTH_FEB)
			+ DOY_W'(d_sel);
		num = NUM_W'(y_sel) * NUM_W'(DAYS_PER_YEAR) + NUM_W'(corr_q) + NUM_W'(doy);
	end

	// Order by the raw fields, then clamp, add the end day and saturate.
	always_comb begin
		first_earlier = {fy_q, fm_q, fd_q} < {sy_q, sm_q, sd_q};
		lo    = first_earlier ? n0_q : n1_q;
		hi    = first_earlier ? n1_q : n0_q;
		diff  = (hi > lo) ? hi - lo : '0;
		sum   = ($bits(sum))'(diff) + ($bits(sum))'(include_end_day_q);
		count = (sum > ($bits(sum))'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			include_end_day_q <= 1'b1;
		end else if (cfg_write_en) begin
			include_end_day_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fy_q  <= first_year;
			fm_q  <= first_month;
			fd_q  <= first_day;
			sy_q  <= second_year;
			sm_q  <= second_month;
			sd_q  <= second_day;
			bad_q <= 1'b0;
		end
		case (cmd.op)
			OP_QUO: begin
				quo_q <= prod[RECIP_SHIFT +: QUO_W];
			end
			OP_YEAR: begin
				leap_q <= leap;
				corr_q <= corr;
			end
			OP_DAY: begin
				if (cmd.sel) begin
					n1_q <= num;
				end else begin
					n0_q <= num;
				end
				bad_q <= bad_q | bad;
			end
			OP_FIN: begin
				day_count_q    <= count;
				date_invalid_q <= bad_q;
			end
			default: begin
			end
		endcase
	end

	assign day_count    = day_count_q;
	assign date_invalid = date_invalid_q;

endmodule

`default_nettype wire

// ===== src/calendar_date_difference_days.sv =====
// Top level: days between two Gregorian dates, controller plus datapath.
//
// Channel  Direction  Handshake            Beat contents
// -------  ---------  -------------------  ---------------------------------------------
// in       to block   in_valid / in_stall  first and second year, month, day
// out      from block out_valid/out_stall  day_count, date_invalid
// cfg      to block   cfg_write_en         cfg_write_data = include_end_day
//
// A beat is accepted only in the idle state; three steps per date on one shared datapath
// (year quotient, leap correction, day number) and one finish step follow, and the finish
// step loads the result; no new beat is taken before the block is back in the idle state.
// in_stall stays high from acceptance until the finish step loads the result.
// The finish step waits only while a stalled result still sits in the output register.
// Reset clears the state machine and output valid and sets include_end_day to 1.
`timescale 1ns / 1ps
`default_nettype none

module calendar_date_difference_days
	import cdd_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire  [YEAR_W-1:0]   first_year,
	input  wire  [MONTH_W-1:0]  first_month,
	input  wire  [DAY_W-1:0]    first_day,
	input  wire  [YEAR_W-1:0]   second_year,
	input  wire  [MONTH_W-1:0]  second_month,
	input  wire  [DAY_W-1:0]    second_day,
	output logic                out_valid,
	input  wire                 out_stall,
	output logic [COUNT_W-1:0]  day_count,
	output logic                date_invalid,
	input  wire                 cfg_write_en,
	input  wire                 cfg_write_data
);

	// Command bundle from the controller to the datapath.
	cmd_t cmd;

	// The controller owns the handshakes and steps the datapath through both dates.
	cdd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// The datapath holds the captured beat, the intermediate terms and the result.
	cdd_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.first_year     (first_year),
		.first_month    (first_month),
		.first_day      (first_day),
		.second_year    (second_year),
		.second_month   (second_month),
		.second_day     (second_day),
		.day_count      (day_count),
		.date_invalid   (date_invalid)
	);

endmodule

`default_nettype wire

// ===== tb/calendar_date_difference_days_tb.sv =====
// Self-checking testbench for the block that counts the days between two dates.
`timescale 1ns / 1ps

module calendar_date_difference_days_tb
	import cdd_pkg::*;
();

	// The run is ended by force if it gets this far. The length of a correct run
	// comes from the block's work on each beat, the sender's gaps and the receiver's stalls.
	localparam int CYCLE_LIMIT = 200000;

	// Ways in which the receiver holds off results. The monitor changes its
	// way at random, so stalls land on every phase of the work.
	typedef enum int {
		STALL_NONE,
		STALL_RANDOM,
		STALL_TOGGLE,
		STALL_HEAVY
	} stall_mode_t;

	// One input beat: a pair of dates, each field at the width of its port.
	typedef struct packed {
		logic [YEAR_W-1:0]  y1;
		logic [MONTH_W-1:0] m1;
		logic [DAY_W-1:0]   d1;
		logic [YEAR_W-1:0]  y2;
		logic [MONTH_W-1:0] m2;
		logic [DAY_W-1:0]   d2;
	} date_pair_t;

	// One output beat as the predictor expects it.
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               invalid;
	} span_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [YEAR_W-1:0]   first_year = '0;
	logic [MONTH_W-1:0]  first_month = '0;
	logic [DAY_W-1:0]    first_day = '0;
	logic [YEAR_W-1:0]   second_year = '0;
	logic [MONTH_W-1:0]  second_month = '0;
	logic [DAY_W-1:0]    second_day = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [COUNT_W-1:0]  day_count;
	logic                date_invalid;
	logic                cfg_write_en = 1'b0;
	logic                cfg_write_data = 1'b0;

	// Date pairs waiting to be sent, and the spans expected back, oldest first.
	date_pair_t  pair_q[$];
	span_t       span_q[$];

	// The testbench's own copy of include_end_day; reset leaves it at one.
	bit          end_day_on = 1'b1;

	int          mismatch_cnt = 0;
	int          cycle_cnt = 0;
	int          burst_left = 0;
	int          gap_left = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int          mode_left = 0;

	calendar_date_difference_days i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.first_year     (first_year),
		.first_month    (first_month),
		.first_day      (first_day),
		.second_year    (second_year),
		.second_month   (second_month),
		.second_day     (second_day),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.day_count      (day_count),
		.date_invalid   (date_invalid),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// ---------------------------------------------------------------------
	// Calendar arithmetic for the predictor.
	// ---------------------------------------------------------------------

	// Gregorian leap rule: every fourth year, but only every fourth century.
	function automatic bit is_leap(int unsigned y);
		return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
	endfunction

	// Length of a month in a given year; zero for a month outside 1 to 12.
	function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return is_leap(y) ? 29 : 28;
			default:               return 0;
		endcase
	endfunction

	// Day number on one continuous line that starts on January 1 of year 0,
	// which is itself a leap year. A date with a bad month or day lands on
	// the day before January 1 of its year and raises the bad flag.
	function automatic int unsigned day_number(int unsigned y, int unsigned m,
			int unsigned d, inout bit bad);
		int unsigned n;
		int unsigned len;
		n = y * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
		len = days_in_month(y, m);
		if (len == 0 || d < 1 || d > len) begin
			bad = 1'b1;
			return n;
		end
		for (int unsigned i = 1; i < m; i++)
			n += days_in_month(y, i);
		return n + d;
	endfunction

	// Expected output beat for one date pair under the given setting.
	function automatic span_t date_span(date_pair_t p, bit add_end);
		span_t       s;
		bit          bad;
		bit          first_earlier;
		int unsigned n1;
		int unsigned n2;
		int unsigned lo;
		int unsigned hi;
		int unsigned diff;
		bad = 1'b0;
		n1 = day_number(32'(p.y1), 32'(p.m1), 32'(p.d1), bad);
		n2 = day_number(32'(p.y2), 32'(p.m2), 32'(p.d2), bad);
		// The order is decided on the raw fields, not on the day numbers, so
		// a bad later date in the same year can give a negative difference.
		if (p.y1 != p.y2)
			first_earlier = p.y1 < p.y2;
		else if (p.m1 != p.m2)
			first_earlier = p.m1 < p.m2;
		else
			first_earlier = p.d1 < p.d2;
		lo = first_earlier ? n1 : n2;
		hi = first_earlier ? n2 : n1;
		// A negative difference is clamped to zero before the end day is added.
		diff = (hi > lo) ? hi - lo : 0;
		diff += 32'(add_end);
		// Years past 11483 or so can overflow the 22-bit count; it saturates.
		if (diff > COUNT_MAX)
			diff = COUNT_MAX;
		s.count = diff[COUNT_W-1:0];
		s.invalid = bad;
		return s;
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus generation.
	// ---------------------------------------------------------------------

	// Years are mostly in the usual range, some near the century rules, and
	// some anywhere in the 14-bit field so that every bit toggles and the
	// count can saturate.
	function automatic logic [YEAR_W-1:0] random_year();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 2)
			return YEAR_W'($urandom_range(0, 16383));
		if (pick < 4)
			return YEAR_W'($urandom_range(1550, 2450));
		return YEAR_W'($urandom_range(0, 9999));
	endfunction

	// A well-formed month and day for the given year.
	function automatic void valid_month_day(logic [YEAR_W-1:0] y,
			output logic [MONTH_W-1:0] m, output logic [DAY_W-1:0] d);
		m = MONTH_W'($urandom_range(1, 12));
		d = DAY_W'($urandom_range(1, days_in_month(32'(y), 32'(m))));
	endfunction

	// Spoil one date: a month out of range, day zero, or a day past the end
	// of its month.
	function automatic void spoil_date(logic [YEAR_W-1:0] y,
			inout logic [MONTH_W-1:0] m, inout logic [DAY_W-1:0] d);
		int unsigned len;
		len = days_in_month(32'(y), 32'(m));
		case ($urandom_range(0, 3))
			0:       m = 4'd0;
			1:       m = MONTH_W'($urandom_range(13, 15));
			2:       d = 5'd0;
			default: d = (len < 31) ? DAY_W'($urandom_range(len + 1, 31)) : 5'd0;
		endcase
	endfunction

	// Most pairs are well formed with random content, a share sits in the
	// same year or month, a share probes February 29, and the rest is spoiled
	// dates or raw noise on every field.
	function automatic date_pair_t random_pair();
		date_pair_t  p;
		int unsigned kind;
		kind = $urandom_range(0, 99);
		p.y1 = random_year();
		p.y2 = random_year();
		valid_month_day(p.y1, p.m1, p.d1);
		valid_month_day(p.y2, p.m2, p.d2);
		if (kind < 50) begin
			// Two well-formed dates in independent years.
		end else if (kind < 65) begin
			p.y2 = p.y1;
			valid_month_day(p.y2, p.m2, p.d2);
			if ($urandom_range(0, 2) == 0) begin
				p.m2 = p.m1;
				p.d2 = DAY_W'($urandom_range(1, days_in_month(32'(p.y2), 32'(p.m2))));
			end
		end else if (kind < 75) begin
			// February 29 in a century year or an arbitrary one.
			p.y1 = ($urandom_range(0, 1) == 0) ? YEAR_W'($urandom_range(0, 99) * 100)
				: random_year();
			p.m1 = MONTH_FEB;
			p.d1 = 5'd29;
		end else if (kind < 88) begin
			if ($urandom_range(0, 1) == 0)
				spoil_date(p.y1, p.m1, p.d1);
			else
				spoil_date(p.y2, p.m2, p.d2);
		end else begin
			p.y1 = YEAR_W'($urandom_range(0, 16383));
			p.m1 = MONTH_W'($urandom_range(0, 15));
			p.d1 = DAY_W'($urandom_range(0, 31));
			p.y2 = YEAR_W'($urandom_range(0, 16383));
			p.m2 = MONTH_W'($urandom_range(0, 15));
			p.d2 = DAY_W'($urandom_range(0, 31));
		end
		return p;
	endfunction

	task automatic send_pair(int unsigned y1, int unsigned m1, int unsigned d1,
			int unsigned y2, int unsigned m2, int unsigned d2);
		date_pair_t p;
		p.y1 = YEAR_W'(y1);
		p.m1 = MONTH_W'(m1);
		p.d1 = DAY_W'(d1);
		p.y2 = YEAR_W'(y2);
		p.m2 = MONTH_W'(m2);
		p.d2 = DAY_W'(d2);
		pair_q.push_back(p);
	endtask

	// Holds the sender back until every date pair is sent and every span has
	// come back, then waits out settle more cycles so the block is truly idle.
	task automatic wait_drained(int settle);
		while (pair_q.size() != 0 || span_q.size() != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	// The register is written only while nothing is in flight, so the
	// predictor's copy can simply follow the write.
	task automatic write_end_day(bit value);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= value;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		end_day_on = value;
		@(negedge clk);
	endtask

	task automatic flag_error(string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("tb: mismatch %0d: %s", mismatch_cnt, msg);
	endtask

	// ---------------------------------------------------------------------
	// Driver: presents date pairs in bursts of random length separated by
	// random gaps. Valid is decided without looking at stall, and a beat that
	// is held off keeps its payload until it is taken.
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				// The beat is taken at this edge; its span is now due.
				span_q.push_back(date_span(pair_q[0], end_day_on));
				void'(pair_q.pop_front());
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pair_q.size() != 0) begin
					in_valid <= 1'b1;
					first_year <= pair_q[0].y1;
					first_month <= pair_q[0].m1;
					first_day <= pair_q[0].d1;
					second_year <= pair_q[0].y2;
					second_month <= pair_q[0].m2;
					second_day <= pair_q[0].d2;
					burst_left--;
					if (burst_left <= 0) begin
						// Now and then a long burst with no gaps at all.
						burst_left = ($urandom_range(0, 4) == 0) ? 30
							: $urandom_range(1, 8);
						gap_left = ($urandom_range(0, 3) == 0) ? 0
							: $urandom_range(1, 12);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: checks each span taken against the oldest one expected, and
	// drives stall on a pattern that changes at random.
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (span_q.size() == 0) begin
					flag_error($sformatf("result with none expected: count %0d invalid %0d",
						day_count, date_invalid));
				end else if (span_q[0].count !== day_count ||
						span_q[0].invalid !== date_invalid) begin
					flag_error($sformatf(
						"expected count %0d invalid %0d, got count %0d invalid %0d",
						span_q[0].count, span_q[0].invalid, day_count, date_invalid));
					void'(span_q.pop_front());
				end else begin
					void'(span_q.pop_front());
				end
			end
			if (mode_left <= 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 80);
			end
			mode_left--;
			case (stall_mode)
				STALL_NONE:   out_stall <= 1'b0;
				STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
				STALL_TOGGLE: out_stall <= ~out_stall;
				STALL_HEAVY:  out_stall <= ($urandom_range(0, 7) != 0);
				default:      out_stall <= 1'b0;
			endcase
		end
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Test sequence.
	// ---------------------------------------------------------------------
	initial begin
		// Reset is held from time zero and released away from the rising
		// edge so that the block's flops see a clean release.
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed pairs under the reset setting, where the end day counts.
		send_pair(2000, 1, 1, 2000, 1, 1);       // same date: only the end day
		send_pair(0, 1, 1, 9999, 12, 31);        // the whole usual year range
		send_pair(9999, 12, 31, 0, 1, 1);        // same pair, reversed order
		send_pair(0, 1, 1, 16383, 12, 31);       // past 22 bits: saturates
		send_pair(16383, 15, 31, 16383, 15, 31); // every field at its top
		send_pair(0, 0, 0, 0, 0, 0);             // every field at zero
		send_pair(0, 2, 29, 0, 3, 1);            // year 0 is a leap year
		send_pair(2000, 2, 29, 2000, 3, 1);      // leap century
		send_pair(1900, 2, 29, 1900, 3, 1);      // century that is not leap
		send_pair(2100, 2, 29, 2400, 2, 29);     // both century rules at once
		send_pair(2004, 2, 29, 2001, 2, 29);     // ordinary leap and non-leap
		send_pair(2020, 0, 15, 2021, 5, 5);      // month zero
		send_pair(2020, 6, 15, 2021, 13, 5);     // month thirteen
		send_pair(1999, 4, 31, 1999, 4, 30);     // day past the month's end
		send_pair(1999, 12, 0, 2000, 1, 1);      // day zero
		// A bad later date in the same year gives a negative difference,
		// which is clamped to zero.
		send_pair(2020, 3, 10, 2020, 13, 5);
		send_pair(2020, 7, 4, 2020, 7, 31);      // same month
		send_pair(2019, 12, 31, 2019, 1, 1);     // same year, reversed
		send_pair(1999, 12, 31, 2000, 1, 1);     // across a year boundary
		send_pair(1600, 3, 1, 1600, 2, 28);      // around a leap day
		wait_drained(12);

		// Corner pairs like those above, with the end day left out.
		write_end_day(1'b0);
		send_pair(2000, 1, 1, 2000, 1, 1);
		send_pair(0, 1, 1, 16383, 12, 31);
		send_pair(2020, 3, 10, 2020, 13, 5);
		send_pair(1900, 2, 28, 1900, 3, 1);
		wait_drained(12);

		// Random pairs in four phases, with the end day left out and counted in turn. In one
		// phase the sender stops halfway until every span is back before it goes on.
		for (int phase = 0; phase < 4; phase++) begin
			write_end_day(phase[0]);
			for (int i = 0; i < 25; i++) begin
				if (phase == 2 && i == 12)
					wait_drained(3);
				pair_q.push_back(random_pair());
			end
			wait_drained(12);
		end

		wait_drained(20);
		if (span_q.size() != 0)
			flag_error($sformatf("%0d expected results never arrived", span_q.size()));
		if (mismatch_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
